FILE: rtl/esrmw_pkg.sv
// Shared definitions for the EEPROM sector read-modify-write controller.
// Holds geometry constants, result kinds, controller states and port structs.
// No dependencies.
package esrmw_pkg;

  localparam int STORE_BYTES      = 2048;
  localparam int SECTOR_BYTES     = 8;
  localparam int PAGE_BYTES       = 1024;
  localparam int MAX_ACCESS_BYTES = 4;

  localparam int ADDR_W   = $clog2(STORE_BYTES);
  localparam int SECT_W   = $clog2(SECTOR_BYTES);
  localparam int ROWS     = STORE_BYTES / SECTOR_BYTES;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int ROW_BITS = 8 * SECTOR_BYTES;
  localparam int PAGE_W   = $clog2(PAGE_BYTES);
  localparam int CNT_W    = 3;
  localparam int DATA_W   = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [2:0] {
    KIND_READ    = 3'd0,
    KIND_ERASE   = 3'd1,
    KIND_PROG    = 3'd2,
    KIND_DONE    = 3'd3,
    KIND_REFUSED = 3'd4,
    KIND_RANGE   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SINGLE,
    ST_RD_LO,
    ST_RD_HI,
    ST_MERGE,
    ST_ERASE,
    ST_PROG,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                rd_en;
    logic [ROW_W-1:0]    rd_row;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_row;
    logic [ROW_BITS-1:0] wr_data;
  } mem_req_t;

  typedef struct packed {
    kind_t             kind;
    logic              page;
    logic [PAGE_W-1:0] page_address;
    logic [DATA_W-1:0] data;
    logic              last;
  } result_t;

endpackage

FILE: rtl/esrmw_store.sv
// Sector-wide store memory with one write port and one registered read port.
// Runs a clearing sweep to the erased value after reset. Uses esrmw_pkg.
module esrmw_store (
  input  logic                          clk,
  input  logic                          rst,
  input  esrmw_pkg::mem_req_t           req,
  output logic [esrmw_pkg::ROW_BITS-1:0] rdata,
  output logic                          busy
);

  logic [esrmw_pkg::ROW_BITS-1:0] mem [esrmw_pkg::ROWS];
  logic [esrmw_pkg::ROW_W-1:0]    clr_row;

  // The sweep writes one erased row per cycle until the last row is done.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_row <= '0;
    end else if (busy) begin
      clr_row <= clr_row + 1'b1;
      if (clr_row == esrmw_pkg::ROW_W'(esrmw_pkg::ROWS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_row] <= '1;
    end else if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rdata <= mem[req.rd_row];
    end
  end

endmodule

FILE: rtl/esrmw_ctrl.sv
// Access sequencer: range and protect checks, read assembly and the sector
// merge, erase and program sequence. Uses esrmw_pkg; drives esrmw_store.
module esrmw_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_op,
  input  logic [esrmw_pkg::ADDR_W-1:0]   in_address,
  input  logic [esrmw_pkg::CNT_W-1:0]    in_byte_count,
  input  logic [esrmw_pkg::DATA_W-1:0]   in_write_data,
  input  logic [esrmw_pkg::ADDR_W-1:0]   protect_limit,
  output logic                           res_valid,
  input  logic                           res_ready,
  output esrmw_pkg::result_t             res,
  output esrmw_pkg::mem_req_t            mem_req,
  input  logic [esrmw_pkg::ROW_BITS-1:0] mem_rdata,
  input  logic                           mem_busy
);

  localparam int AW = esrmw_pkg::ADDR_W;
  localparam int SW = esrmw_pkg::SECT_W;
  localparam int CW = esrmw_pkg::CNT_W;
  localparam int DW = esrmw_pkg::DATA_W;
  localparam int RB = esrmw_pkg::ROW_BITS;
  localparam int PW = esrmw_pkg::PAGE_W;

  esrmw_pkg::state_t state, state_next;
  esrmw_pkg::kind_t  err_kind;

  logic [AW-1:0] addr_r;
  logic [CW-1:0] cnt_r;
  logic [DW-1:0] wl;
  logic [AW-1:0] cur;
  logic [CW-1:0] done_n;
  logic [esrmw_pkg::ROW_W-1:0] row_r;
  logic [SW-1:0] prog_i;
  logic [RB-1:0] sbuf;

  logic          accept;
  logic          range_err;
  logic          prot;
  logic [AW:0]   end_sum;

  logic [SW-1:0] off;
  logic [SW:0]   room;
  logic [CW-1:0] rem;
  logic [SW:0]   len;
  logic [7:0]    wb [esrmw_pkg::MAX_ACCESS_BYTES];
  logic [RB-1:0] merged;
  logic          differ;
  logic [AW-1:0] cur_next;
  logic [CW-1:0] done_next;
  logic          more_next;
  logic          more;
  logic          prog_end;

  logic [2*RB-1:0] rd_shift;
  logic [DW-1:0]   rd_word;
  logic [DW-1:0]   rd_data;
  logic [AW-1:0]   prog_addr;
  logic [AW-1:0]   erase_addr;

  assign in_ready = (state == esrmw_pkg::ST_IDLE) && !mem_busy;
  assign accept   = in_valid && in_ready;

  assign end_sum   = (AW+1)'(in_address) + (AW+1)'(in_byte_count);
  assign range_err = (in_byte_count == '0) ||
                     (in_byte_count > CW'(esrmw_pkg::MAX_ACCESS_BYTES)) ||
                     (end_sum > (AW+1)'(esrmw_pkg::STORE_BYTES));
  assign prot      = in_address <= protect_limit;

  // Merge of the fetched sector with the bytes that fall into it.
  assign off  = cur[SW-1:0];
  assign room = (SW+1)'(esrmw_pkg::SECTOR_BYTES) - (SW+1)'(off);
  assign rem  = cnt_r - done_n;
  assign len  = ((SW+1)'(rem) < room) ? (SW+1)'(rem) : room;

  always_comb begin
    for (int k = 0; k < esrmw_pkg::MAX_ACCESS_BYTES; k++) begin
      wb[k] = wl[DW-1-8*k -: 8];
    end
  end

  always_comb begin
    logic [SW:0] pos;
    logic [1:0]  j;
    logic        hit;
    logic [7:0]  old;
    merged = '0;
    differ = 1'b0;
    for (int i = 0; i < esrmw_pkg::SECTOR_BYTES; i++) begin
      pos = (SW+1)'(i);
      j   = done_n[1:0] + 2'(i) - off[1:0];
      hit = (pos >= (SW+1)'(off)) && (pos < ((SW+1)'(off) + len));
      old = mem_rdata[8*i +: 8];
      merged[8*i +: 8] = hit ? wb[j] : old;
      if (hit && (wb[j] != old)) begin
        differ = 1'b1;
      end
    end
  end

  assign cur_next  = cur + AW'(len);
  assign done_next = done_n + CW'(len);
  assign more_next = done_next < cnt_r;
  assign more      = done_n < cnt_r;
  assign prog_end  = res_ready && (prog_i == SW'(esrmw_pkg::SECTOR_BYTES - 1));

  // Read assembly: low sector sits in sbuf, the following one on the memory port.
  assign rd_shift = {mem_rdata, sbuf} >> {addr_r[SW-1:0], 3'b000};
  assign rd_word  = {rd_shift[7:0], rd_shift[15:8], rd_shift[23:16], rd_shift[31:24]};
  assign rd_data  = rd_word >> {3'(esrmw_pkg::MAX_ACCESS_BYTES) - cnt_r, 3'b000};

  assign prog_addr  = {row_r, prog_i};
  assign erase_addr = {row_r, SW'(0)};

  always_comb begin
    state_next = state;
    case (state)
      esrmw_pkg::ST_IDLE: begin
        if (accept) begin
          if (range_err || (in_op && prot)) begin
            state_next = esrmw_pkg::ST_SINGLE;
          end else if (!in_op) begin
            state_next = esrmw_pkg::ST_RD_LO;
          end else begin
            state_next = esrmw_pkg::ST_MERGE;
          end
        end
      end
      esrmw_pkg::ST_SINGLE: if (res_ready) state_next = esrmw_pkg::ST_IDLE;
      esrmw_pkg::ST_RD_LO:  state_next = esrmw_pkg::ST_RD_HI;
      esrmw_pkg::ST_RD_HI:  if (res_ready) state_next = esrmw_pkg::ST_IDLE;
      esrmw_pkg::ST_MERGE: begin
        if (differ) begin
          state_next = esrmw_pkg::ST_ERASE;
        end else if (more_next) begin
          state_next = esrmw_pkg::ST_MERGE;
        end else begin
          state_next = esrmw_pkg::ST_DONE;
        end
      end
      esrmw_pkg::ST_ERASE:  if (res_ready) state_next = esrmw_pkg::ST_PROG;
      esrmw_pkg::ST_PROG: begin
        if (prog_end) begin
          state_next = more ? esrmw_pkg::ST_MERGE : esrmw_pkg::ST_DONE;
        end
      end
      esrmw_pkg::ST_DONE:   if (res_ready) state_next = esrmw_pkg::ST_IDLE;
      default:              state_next = esrmw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    res_valid        = 1'b0;
    res.kind         = esrmw_pkg::KIND_DONE;
    res.page         = 1'b0;
    res.page_address = '0;
    res.data         = '0;
    res.last         = 1'b1;
    mem_req.rd_en    = 1'b0;
    mem_req.rd_row   = in_address[AW-1:SW];
    mem_req.wr_en    = 1'b0;
    mem_req.wr_row   = row_r;
    mem_req.wr_data  = sbuf;
    case (state)
      esrmw_pkg::ST_IDLE: begin
        mem_req.rd_en = accept;
      end
      esrmw_pkg::ST_SINGLE: begin
        res_valid        = 1'b1;
        res.kind         = err_kind;
        res.page         = addr_r[PW];
        res.page_address = addr_r[PW-1:0];
      end
      esrmw_pkg::ST_RD_LO: begin
        mem_req.rd_en  = 1'b1;
        mem_req.rd_row = addr_r[AW-1:SW] + 1'b1;
      end
      esrmw_pkg::ST_RD_HI: begin
        res_valid        = 1'b1;
        res.kind         = esrmw_pkg::KIND_READ;
        res.page         = addr_r[PW];
        res.page_address = addr_r[PW-1:0];
        res.data         = rd_data;
      end
      esrmw_pkg::ST_MERGE: begin
        mem_req.rd_en  = !differ && more_next;
        mem_req.rd_row = cur_next[AW-1:SW];
      end
      esrmw_pkg::ST_ERASE: begin
        res_valid        = 1'b1;
        res.kind         = esrmw_pkg::KIND_ERASE;
        res.page         = erase_addr[PW];
        res.page_address = erase_addr[PW-1:0];
        res.last         = 1'b0;
        mem_req.wr_en    = res_ready;
      end
      esrmw_pkg::ST_PROG: begin
        res_valid        = 1'b1;
        res.kind         = esrmw_pkg::KIND_PROG;
        res.page         = prog_addr[PW];
        res.page_address = prog_addr[PW-1:0];
        res.data         = DW'(sbuf[8*prog_i +: 8]);
        res.last         = 1'b0;
        mem_req.rd_en    = prog_end && more;
        mem_req.rd_row   = cur[AW-1:SW];
      end
      esrmw_pkg::ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esrmw_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      esrmw_pkg::ST_IDLE: begin
        if (accept) begin
          addr_r   <= in_address;
          cnt_r    <= in_byte_count;
          wl       <= in_write_data <<
                      {3'(esrmw_pkg::MAX_ACCESS_BYTES) - in_byte_count, 3'b000};
          err_kind <= range_err ? esrmw_pkg::KIND_RANGE : esrmw_pkg::KIND_REFUSED;
          cur      <= in_address;
          done_n   <= '0;
        end
      end
      esrmw_pkg::ST_RD_LO: begin
        sbuf <= mem_rdata;
      end
      esrmw_pkg::ST_MERGE: begin
        sbuf   <= merged;
        row_r  <= cur[AW-1:SW];
        cur    <= cur_next;
        done_n <= done_next;
        prog_i <= '0;
      end
      esrmw_pkg::ST_PROG: begin
        if (res_ready) begin
          prog_i <= prog_i + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: rtl/eeprom_sector_rmw_controller.sv
// Top level of the EEPROM sector read-modify-write controller.
// Depends on esrmw_pkg, esrmw_store and esrmw_ctrl.
//
// The block keeps a 2 KiB byte store (two 1 KiB pages, 8-byte sectors) in a
// single memory of 256 sector-wide rows with a registered read. After reset
// it sweeps every row to the erased value 0xFF; s_axis_tready stays low for
// that time, while protect_limit writes are taken as usual. Input words are
// taken one at a time: a range error or a refused write gives one result
// word, a read does two sector fetches (a read may straddle a sector
// boundary), and a write fetches and merges each touched sector and, when
// any byte differs, emits 9 more result words (one erase, eight byte
// programs), then the write done word. The pace is set by the one read and
// one write port of the store and by the at most one result word emitted
// per cycle while the result side is ready. A finished result waits in an
// output register, so the next input word can be taken while it is held;
// backpressure on the result side stalls the sequence word by word.
module eeprom_sector_rmw_controller (
  input  logic        clk,
  input  logic        rst,
  // Input words.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // address[10:0], byte_count[13:11],
                                     // write_data[45:14], zero[47:46]
  input  logic        s_axis_tuser,  // op: 0 read, 1 write
  // Result words.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // page[0], page_address[10:1],
                                     // data[42:11], zero[47:43]
  output logic [2:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,  // last word caused by the input word
  // Protect limit register.
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);

  localparam int AW = esrmw_pkg::ADDR_W;
  localparam int CW = esrmw_pkg::CNT_W;
  localparam int DW = esrmw_pkg::DATA_W;
  localparam int PW = esrmw_pkg::PAGE_W;

  logic [AW-1:0]          protect_limit;
  logic                   res_valid;
  logic                   res_ready;
  esrmw_pkg::result_t     res;
  esrmw_pkg::result_t     out_r;
  esrmw_pkg::mem_req_t    mem_req;
  logic [esrmw_pkg::ROW_BITS-1:0] mem_rdata;
  logic                   mem_busy;

  // Writes at or below this address are refused; reset value is 512.
  always_ff @(posedge clk) begin
    if (rst) begin
      protect_limit <= AW'(512);
    end else if (cfg_we) begin
      protect_limit <= cfg_wdata;
    end
  end

  esrmw_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (mem_req),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  esrmw_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_axis_tvalid),
    .in_ready      (s_axis_tready),
    .in_op         (s_axis_tuser),
    .in_address    (s_axis_tdata[AW-1:0]),
    .in_byte_count (s_axis_tdata[AW+CW-1:AW]),
    .in_write_data (s_axis_tdata[AW+CW+DW-1:AW+CW]),
    .protect_limit (protect_limit),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .res           (res),
    .mem_req       (mem_req),
    .mem_rdata     (mem_rdata),
    .mem_busy      (mem_busy)
  );

  // Output register: loads whenever it is empty or being emptied this cycle.
  assign res_ready = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign m_axis_tdata = {(esrmw_pkg::OUT_TDATA_W - 1 - PW - DW)'(0),
                         out_r.data, out_r.page_address, out_r.page};
  assign m_axis_tuser = out_r.kind;
  assign m_axis_tlast = out_r.last;

endmodule

FILE: rtl/esrmw_checker.sv
// Port-level checks for the EEPROM sector read-modify-write controller.
// Depends on esrmw_pkg; bound to eeprom_sector_rmw_controller below.
module esrmw_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A held result word keeps its contents until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // The clearing sweep keeps the input closed right after reset.
  a_clear_closed: assert property (@(posedge clk)
    $past(rst) |-> !s_axis_tready)
    else $error("input open during the clearing sweep");

  // Only one input word is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second input word taken while busy");

  // Only erase and program words may be followed by more words of the same input.
  a_not_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      (m_axis_tuser == esrmw_pkg::KIND_ERASE) ||
      (m_axis_tuser == esrmw_pkg::KIND_PROG))
    else $error("non-final word of an unexpected kind");

endmodule

bind eeprom_sector_rmw_controller esrmw_checker u_esrmw_checker (.*);

FILE: tb/eeprom_sector_rmw_controller_tb.sv
// Self-checking bench for the EEPROM sector read-modify-write controller.
// Predicts every result word from a shadow store. Needs esrmw_pkg and the RTL.
`timescale 1ns / 100ps

module eeprom_sector_rmw_controller_tb;
  import esrmw_pkg::*;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;
  localparam int   HOT_SPAN = 64;

  typedef struct {
    logic        op;
    logic [10:0] addr;
    logic [2:0]  cnt;
    logic [31:0] wdata;
  } access_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [10:0] cfg_wdata = '0;

  // Words waiting to be offered, and result words the block still owes us.
  access_t access_q[$];
  result_t pending_results[$];

  // Shadow of the store and of the protect limit register.
  logic [7:0]  eeprom_img [0:STORE_BYTES-1];
  logic [10:0] limit_val = 11'd512;

  access_t cur_access;
  int      accepted_cnt = 0;
  int      mismatch_cnt = 0;
  int      burst_left = 0;
  int      gap_left = 0;

  always #5 clk = ~clk;

  eeprom_sector_rmw_controller dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata)
  );

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    // Keep the log readable if something goes badly wrong.
    if (mismatch_cnt <= 50) begin
      $display("%0t ERROR: %s", $realtime, msg);
    end
  endtask

  function automatic result_t make_result(kind_t k, int a, logic [31:0] d);
    result_t r;
    r.kind         = k;
    r.page         = (a >= PAGE_BYTES);
    r.page_address = 10'(a % PAGE_BYTES);
    r.data         = d;
    r.last         = 1'b0;
    return r;
  endfunction

  // Works out the result words one accepted input word causes and applies any
  // programming to the shadow store. Results go out strictly in order, so the
  // expectations are simply appended.
  task automatic predict_results(input access_t w);
    result_t     res[$];
    logic [7:0]  new_bytes [0:3];
    logic [7:0]  merged [0:SECTOR_BYTES-1];
    logic [31:0] v;
    int          a, cnt, done, off, base, len, sa;
    bit          differ;
    a   = w.addr;
    cnt = w.cnt;
    if (cnt == 0 || cnt > MAX_ACCESS_BYTES || a + cnt > STORE_BYTES) begin
      // Range check wins over everything else, even on a protected address.
      res.push_back(make_result(KIND_RANGE, a, '0));
    end else if (w.op == OP_READ) begin
      v = '0;
      for (int i = 0; i < cnt; i++) v = (v << 8) | eeprom_img[a + i];
      res.push_back(make_result(KIND_READ, a, v));
    end else if (w.addr <= limit_val) begin
      res.push_back(make_result(KIND_REFUSED, a, '0));
    end else begin
      // Big-endian: the first address takes the most significant used byte.
      for (int i = 0; i < cnt; i++) new_bytes[i] = 8'(w.wdata >> (8 * (cnt - 1 - i)));
      done = 0;
      while (done < cnt) begin
        sa   = a + done;
        off  = sa % SECTOR_BYTES;
        base = sa - off;
        len  = (cnt - done < SECTOR_BYTES - off) ? cnt - done : SECTOR_BYTES - off;
        differ = 1'b0;
        for (int i = 0; i < SECTOR_BYTES; i++) begin
          if (i >= off && i < off + len) begin
            merged[i] = new_bytes[done + i - off];
            if (merged[i] != eeprom_img[base + i]) differ = 1'b1;
          end else begin
            merged[i] = eeprom_img[base + i];
          end
        end
        // A sector whose bytes already match is left alone entirely.
        if (differ) begin
          res.push_back(make_result(KIND_ERASE, base, '0));
          for (int i = 0; i < SECTOR_BYTES; i++) begin
            eeprom_img[base + i] = merged[i];
            res.push_back(make_result(KIND_PROG, base + i, {24'd0, merged[i]}));
          end
        end
        done += len;
      end
      res.push_back(make_result(KIND_DONE, 0, '0));
    end
    res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  // Input side: offers words in bursts of random length with random gaps.
  // A word once offered is held until the block takes it.
  always @(posedge clk) begin : input_driver
    access_t nxt;
    bit      fire;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      fire = s_axis_tvalid && s_axis_tready;
      if (fire) begin
        predict_results(cur_access);
        accepted_cnt++;
      end
      if (!s_axis_tvalid || fire) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (access_q.size() > 0) begin
          nxt = access_q.pop_front();
          cur_access    <= nxt;
          s_axis_tdata  <= {2'b00, nxt.wdata, nxt.cnt, nxt.addr};
          s_axis_tuser  <= nxt.op;
          s_axis_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
          end
          burst_left--;
          // End of a burst: a quarter of the time run straight into the next.
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: the ready pattern cycles through always ready, mostly ready,
  // mostly stalled and a fixed periodic pattern. Once the run is well under
  // way it also holds off for a long stretch while input keeps coming, so the
  // output register and the input side both back up.
  always @(posedge clk) begin : result_ready_gen
    logic [10:0] cyc;
    int          hold_left;
    bit          hold_done;
    logic        rdy;
    if (rst) begin
      cyc       = '0;
      hold_left = 0;
      hold_done = 1'b0;
      m_axis_tready <= 1'b0;
    end else begin
      cyc++;
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!hold_done && accepted_cnt >= 60) begin
        hold_done = 1'b1;
        hold_left = 400;
        rdy = 1'b0;
      end else begin
        case (cyc[10:9])
          2'd0: rdy = 1'b1;
          2'd1: rdy = ($urandom_range(0, 3) != 0);
          2'd2: rdy = ($urandom_range(0, 3) == 0);
          default: rdy = (cyc[2:0] != 3'd5) && !(cyc[5:3] == 3'd7);
        endcase
      end
      m_axis_tready <= rdy;
    end
  end

  // Result checking: every accepted word is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin : result_monitor
    result_t exp_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result word kind=%0d tdata=%h",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        exp_r = pending_results.pop_front();
        if (m_axis_tuser != exp_r.kind)
          report_mismatch($sformatf("kind %0d, expected %0d",
                                    m_axis_tuser, exp_r.kind));
        if (m_axis_tdata[0] != exp_r.page)
          report_mismatch($sformatf("page %0d, expected %0d (kind %0d)",
                                    m_axis_tdata[0], exp_r.page, exp_r.kind));
        if (m_axis_tdata[10:1] != exp_r.page_address)
          report_mismatch($sformatf("page_address %0d, expected %0d (kind %0d)",
                                    m_axis_tdata[10:1], exp_r.page_address,
                                    exp_r.kind));
        if (m_axis_tdata[42:11] != exp_r.data)
          report_mismatch($sformatf("data %h, expected %h (kind %0d)",
                                    m_axis_tdata[42:11], exp_r.data, exp_r.kind));
        if (m_axis_tlast != exp_r.last)
          report_mismatch($sformatf("last %0d, expected %0d (kind %0d)",
                                    m_axis_tlast, exp_r.last, exp_r.kind));
      end
    end
  end

  function automatic access_t mk_access(logic op, int addr, int cnt, logic [31:0] wd);
    access_t w;
    w.op    = op;
    w.addr  = 11'(addr);
    w.cnt   = 3'(cnt);
    w.wdata = wd;
    return w;
  endfunction

  // Random word, biased toward a small hot region above the protect limit so
  // that reads see written data and rewrites often find bytes unchanged.
  function automatic access_t random_access(int hot);
    access_t w;
    int      sel;
    w.op  = ($urandom_range(0, 99) < 55) ? OP_WRITE : OP_READ;
    w.cnt = 3'($urandom_range(1, 4));
    if ($urandom_range(0, 99) < 8) begin
      w.cnt = $urandom_range(0, 1) ? 3'd0 : 3'($urandom_range(5, 7));
    end
    sel = $urandom_range(0, 99);
    if (sel < 10)      w.addr = 11'($urandom_range(2040, 2047));
    else if (sel < 20) w.addr = 11'($urandom_range(1016, 1031));
    else if (sel < 32) w.addr = 11'($urandom);
    else               w.addr = 11'(hot + $urandom_range(0, HOT_SPAN - 1));
    if ($urandom_range(0, 1)) begin
      w.wdata = $urandom;
    end else begin
      // Few distinct byte values make repeated writes hit matching bytes.
      for (int i = 0; i < 4; i++) begin
        case ($urandom_range(0, 3))
          0: w.wdata[8*i +: 8] = 8'h00;
          1: w.wdata[8*i +: 8] = 8'hFF;
          2: w.wdata[8*i +: 8] = 8'h5A;
          default: w.wdata[8*i +: 8] = 8'hA5;
        endcase
      end
    end
    return w;
  endfunction

  // Waits until everything queued has gone through and every expected word
  // has come back, then leaves the block a little time to settle.
  task automatic wait_idle();
    while (access_q.size() > 0 || s_axis_tvalid || pending_results.size() > 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_protect_limit(input logic [10:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_val = v;
  endtask

  initial begin : stimulus
    int lim, lo, hot;
    for (int i = 0; i < STORE_BYTES; i++) eeprom_img[i] = 8'hFF;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed part with nothing protected but address 0.
    write_protect_limit(11'd0);
    access_q.push_back(mk_access(OP_READ,  0,    4, 32'h0));           // erased store
    access_q.push_back(mk_access(OP_WRITE, 0,    1, 32'h12));          // at the limit
    access_q.push_back(mk_access(OP_WRITE, 1,    1, 32'hFFFF_FFAB));   // one sector
    access_q.push_back(mk_access(OP_WRITE, 1,    1, 32'h0000_00AB));   // no change
    access_q.push_back(mk_access(OP_WRITE, 6,    4, 32'h0102_0304));   // two sectors
    access_q.push_back(mk_access(OP_WRITE, 5,    4, 32'hFF01_0203));   // no change
    access_q.push_back(mk_access(OP_READ,  5,    4, 32'h0));
    access_q.push_back(mk_access(OP_WRITE, 1022, 4, 32'hDEAD_BEEF));   // across pages
    access_q.push_back(mk_access(OP_READ,  1022, 4, 32'h0));
    access_q.push_back(mk_access(OP_READ,  1023, 2, 32'h0));
    access_q.push_back(mk_access(OP_WRITE, 2040, 4, 32'h0000_0000));
    access_q.push_back(mk_access(OP_WRITE, 2044, 4, 32'hFFFF_FFFF));   // already erased
    access_q.push_back(mk_access(OP_WRITE, 2047, 1, 32'h0000_005A));   // last byte
    access_q.push_back(mk_access(OP_READ,  2044, 4, 32'h0));
    access_q.push_back(mk_access(OP_READ,  2045, 4, 32'h0));           // past the end
    access_q.push_back(mk_access(OP_WRITE, 2047, 2, 32'h1234));        // past the end
    access_q.push_back(mk_access(OP_READ,  100,  0, 32'h0));           // bad count
    access_q.push_back(mk_access(OP_READ,  100,  5, 32'h0));
    access_q.push_back(mk_access(OP_WRITE, 0,    7, 32'h0));           // bad count wins
    access_q.push_back(mk_access(OP_WRITE, 2047, 6, 32'hFFFF_FFFF));
    wait_idle();

    // Everything protected.
    write_protect_limit(11'd2047);
    access_q.push_back(mk_access(OP_WRITE, 2047, 1, 32'h0000_0011));
    access_q.push_back(mk_access(OP_WRITE, 1500, 3, 32'h00AB_CDEF));
    access_q.push_back(mk_access(OP_READ,  1020, 4, 32'h0));
    wait_idle();

    // Random phases under several limits, ending on the reset value.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: lim = $urandom_range(1, 100);
        1: lim = 1023;
        2: lim = $urandom_range(1500, 1900);
        default: lim = 512;
      endcase
      write_protect_limit(11'(lim));
      lo  = (lim + 1 > STORE_BYTES - HOT_SPAN) ? STORE_BYTES - HOT_SPAN : lim + 1;
      hot = $urandom_range(lo, STORE_BYTES - HOT_SPAN);
      for (int n = 0; n < 77; n++) access_q.push_back(random_access(hot));
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run, including the erase sweep after reset.
  initial begin : watchdog
    #5ms;
    $display("simulation failed");
    $finish;
  end

endmodule
